// ----- design/afoc_pkg.sv -----
`timescale 1ns / 1ps

package afoc_pkg;

    // Frame layout
    localparam int FIELD_CHANNELS   = 4;
    localparam int CHANNELS_DEFAULT = 4;
    localparam int CODE_W           = 24;
    localparam int VALUE_W          = 25;
    localparam int STATUS_W         = 24;
    localparam int MODE_W           = 2;

    // Configuration registers
    localparam int SKIP_W    = 8;
    localparam int CAL_LEN_W = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = CAL_LEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_SKIPPED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_LENGTH     = 1'd1;

    localparam logic [SKIP_W-1:0]    FRAMES_SKIPPED_RST = 8'd10;
    localparam logic [CAL_LEN_W-1:0] CAL_LENGTH_RST     = 10'd200;

    // Frame modes; the unused code behaves as a raw frame
    localparam logic [MODE_W-1:0] MODE_RAW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CORR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CAL  = 2'd2;

    // Per-frame command from the control unit to every lane
    typedef struct packed {
        logic fire;   // frame transferred and kept
        logic cal;    // calibration frame
        logic first;  // first sample of a calibration run
        logic latch;  // run completes: averages become offsets
        logic corr;   // subtract stored offset
    } lane_ctrl_t;

endpackage

// ----- design/afoc_ctrl.sv -----
`timescale 1ns / 1ps

module afoc_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [afoc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [afoc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               accept,
    input  logic [afoc_pkg::MODE_W-1:0]        mode,
    output afoc_pkg::lane_ctrl_t               lane_ctrl,
    output logic                               produce
);
    import afoc_pkg::*;

    logic [SKIP_W-1:0]    frames_skipped_reg;
    logic [CAL_LEN_W-1:0] cal_length_reg;
    logic [SKIP_W-1:0]    skip_reg;
    logic [SKIP_W-1:0]    skip_next;
    logic [CAL_LEN_W-1:0] count_reg;
    logic [CAL_LEN_W-1:0] count_next;
    logic [CAL_LEN_W-1:0] count_inc;
    logic [CAL_LEN_W-1:0] eff_len;
    logic                 keep;
    logic                 is_cal;
    logic                 complete;

    // Decide keep, run progress and completion for the offered frame
    always_comb
    begin
        keep      = (skip_reg >= frames_skipped_reg);
        is_cal    = (mode == MODE_CAL);
        eff_len   = (cal_length_reg == '0) ? CAL_LEN_W'(1) : cal_length_reg;
        count_inc = count_reg + CAL_LEN_W'(1);
        complete  = (count_inc >= eff_len) || (count_inc == '0);

        skip_next  = skip_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (!keep)
            begin
                skip_next = skip_reg + SKIP_W'(1);
            end
            else
            begin
                skip_next = '0;
                if (is_cal && !complete)
                begin
                    count_next = count_inc;
                end
                else
                begin
                    count_next = '0;
                end
            end
        end

        lane_ctrl.fire  = accept && keep;
        lane_ctrl.cal   = is_cal;
        lane_ctrl.first = (count_reg == '0);
        lane_ctrl.latch = is_cal && complete;
        lane_ctrl.corr  = (mode == MODE_CORR);
        produce         = keep && (!is_cal || complete);
    end

    // Hold configuration and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_skipped_reg <= FRAMES_SKIPPED_RST;
            cal_length_reg     <= CAL_LENGTH_RST;
            skip_reg           <= '0;
            count_reg          <= '0;
        end
        else
        begin
            skip_reg  <= skip_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAMES_SKIPPED: frames_skipped_reg <= cfg_data[SKIP_W-1:0];
                    REG_CAL_LENGTH:     cal_length_reg     <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

endmodule

// ----- design/afoc_lane.sv -----
`timescale 1ns / 1ps

module afoc_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  afoc_pkg::lane_ctrl_t                lane_ctrl,
    input  logic signed [afoc_pkg::CODE_W-1:0]  code,
    output logic signed [afoc_pkg::VALUE_W-1:0] value
);
    import afoc_pkg::*;

    logic signed [CODE_W-1:0]  avg_reg;
    logic signed [CODE_W-1:0]  offset_reg;
    logic signed [CODE_W-1:0]  seed;
    logic signed [VALUE_W-1:0] sum;
    logic        [VALUE_W-1:0] sum_adj;
    logic signed [CODE_W-1:0]  avg_next;

    // Halving average, truncated toward zero
    always_comb
    begin
        seed     = lane_ctrl.first ? code : avg_reg;
        sum      = VALUE_W'(seed) + VALUE_W'(code);
        sum_adj  = sum + {{(VALUE_W-1){1'b0}}, sum[VALUE_W-1]};
        avg_next = sum_adj[VALUE_W-1:1];
    end

    // Select new offset, corrected code or raw code
    always_comb
    begin
        if (lane_ctrl.latch)
        begin
            value = VALUE_W'(avg_next);
        end
        else if (lane_ctrl.corr)
        begin
            value = VALUE_W'(code) - VALUE_W'(offset_reg);
        end
        else
        begin
            value = VALUE_W'(code);
        end
    end

    // Advance the average and latch offsets at run end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg    <= '0;
            offset_reg <= '0;
        end
        else if (lane_ctrl.fire && lane_ctrl.cal)
        begin
            avg_reg <= avg_next;
            if (lane_ctrl.latch)
            begin
                offset_reg <= avg_next;
            end
        end
    end

endmodule

// ----- design/adc_frame_offset_calibrator.sv -----
`timescale 1ns / 1ps

// Channel  Handshake           Payload
// in       in_valid/in_ready   mode, status_word, code_ch0..code_ch3
// out      out_valid/out_ready status_out, value_ch0..value_ch3, calibration_done
// cfg      cfg_we              cfg_index, cfg_data
//
// One frame per cycle while in_ready is high; a result appears in the cycle after its frame transfers.
// The per-channel add and halve in each lane is combinational.
// Dropped frames and partial calibration frames give no result.
// Reset restores skip 10, length 200 and clears counters, averages and offsets.
// A single output register parts the sides; in_ready holds low only while a
// result waits and out_ready is low.

module adc_frame_offset_calibrator #(
    parameter int CHANNELS = afoc_pkg::CHANNELS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [afoc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [afoc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [afoc_pkg::MODE_W-1:0]          mode,
    input  logic [afoc_pkg::STATUS_W-1:0]        status_word,
    input  logic signed [afoc_pkg::CODE_W-1:0]   code_ch0,
    input  logic signed [afoc_pkg::CODE_W-1:0]   code_ch1,
    input  logic signed [afoc_pkg::CODE_W-1:0]   code_ch2,
    input  logic signed [afoc_pkg::CODE_W-1:0]   code_ch3,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [afoc_pkg::STATUS_W-1:0]        status_out,
    output logic signed [afoc_pkg::VALUE_W-1:0]  value_ch0,
    output logic signed [afoc_pkg::VALUE_W-1:0]  value_ch1,
    output logic signed [afoc_pkg::VALUE_W-1:0]  value_ch2,
    output logic signed [afoc_pkg::VALUE_W-1:0]  value_ch3,
    output logic                                 calibration_done
);
    import afoc_pkg::*;

    lane_ctrl_t               lane_ctrl;
    logic                     accept;
    logic                     produce;
    logic signed [CODE_W-1:0]  code_arr  [FIELD_CHANNELS];
    logic signed [VALUE_W-1:0] value_arr [FIELD_CHANNELS];

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic                      done_reg;
    logic signed [VALUE_W-1:0] value_reg [FIELD_CHANNELS];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign code_arr[0] = code_ch0;
    assign code_arr[1] = code_ch1;
    assign code_arr[2] = code_ch2;
    assign code_arr[3] = code_ch3;

    afoc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .mode      (mode),
        .lane_ctrl (lane_ctrl),
        .produce   (produce)
    );

    // One lane per processed channel; absent channels read as zero
    for (genvar c = 0; c < FIELD_CHANNELS; c++)
    begin : g_lane
        if (c < CHANNELS)
        begin : g_on
            afoc_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .lane_ctrl (lane_ctrl),
                .code      (code_arr[c]),
                .value     (value_arr[c])
            );
        end
        else
        begin : g_off
            assign value_arr[c] = '0;
        end
    end

    // Track the output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = produce;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Merge lane results into the output register
    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            status_reg <= status_word;
            done_reg   <= lane_ctrl.latch;
            for (int c = 0; c < FIELD_CHANNELS; c++)
            begin
                value_reg[c] <= value_arr[c];
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign status_out       = status_reg;
    assign calibration_done = done_reg;
    assign value_ch0        = value_reg[0];
    assign value_ch1        = value_reg[1];
    assign value_ch2        = value_reg[2];
    assign value_ch3        = value_reg[3];

endmodule

// ----- verif/adc_frame_offset_calibrator_test.sv -----
`timescale 1ns / 1ps

module adc_frame_offset_calibrator_test;

    import afoc_pkg::*;

    localparam int NUM_LANES    = CHANNELS_DEFAULT;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;

    // spare mode code, handled like a raw frame
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // pressure kinds for a random phase
    localparam int PRESS_NONE  = 0;
    localparam int PRESS_HOLD  = 1;
    localparam int PRESS_PAUSE = 2;

    typedef struct packed {
        logic [MODE_W-1:0]                        op;
        logic [STATUS_W-1:0]                      status;
        logic [FIELD_CHANNELS-1:0][CODE_W-1:0]    code;
    } frame_t;

    typedef struct packed {
        logic [STATUS_W-1:0]                      status;
        logic [FIELD_CHANNELS-1:0][VALUE_W-1:0]   value;
        logic                                     done;
    } result_t;

    typedef struct packed {
        frame_t  f;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic [MODE_W-1:0]             mode;
    logic [STATUS_W-1:0]           status_word;
    logic signed [CODE_W-1:0]      code_ch0;
    logic signed [CODE_W-1:0]      code_ch1;
    logic signed [CODE_W-1:0]      code_ch2;
    logic signed [CODE_W-1:0]      code_ch3;
    logic                          out_valid;
    logic                          out_ready;
    logic [STATUS_W-1:0]           status_out;
    logic signed [VALUE_W-1:0]     value_ch0;
    logic signed [VALUE_W-1:0]     value_ch1;
    logic signed [VALUE_W-1:0]     value_ch2;
    logic signed [VALUE_W-1:0]     value_ch3;
    logic                          calibration_done;

    adc_frame_offset_calibrator #(
        .CHANNELS(NUM_LANES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .status_word(status_word),
        .code_ch0(code_ch0),
        .code_ch1(code_ch1),
        .code_ch2(code_ch2),
        .code_ch3(code_ch3),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status_out(status_out),
        .value_ch0(value_ch0),
        .value_ch1(value_ch1),
        .value_ch2(value_ch2),
        .value_ch3(value_ch3),
        .calibration_done(calibration_done)
    );

    // calibrator state mirrored on the test side
    logic [SKIP_W-1:0]    skip_cfg;
    logic [CAL_LEN_W-1:0] cal_len_cfg;
    logic [SKIP_W-1:0]    skip_count;
    logic [CAL_LEN_W-1:0] cal_count;
    int                   offset_mem [FIELD_CHANNELS];
    int                   avg_mem [FIELD_CHANNELS];

    result_t   owed_results[$];
    stim_row_t directed_rows[$];
    result_t   got_result;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int cycle_count;
    int mismatches;
    int frames_sent;
    int results_seen;
    int offsets_latched;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // work out the result of one transferred frame and advance the mirrored state
    function automatic logic compute_frame_result(input frame_t f, output result_t r);
        int c;
        int x;
        int a;
        int v;
        int len_eff;
        r = '0;
        if (skip_count < skip_cfg)
        begin
            skip_count = skip_count + 1'b1;
            return 1'b0;
        end
        skip_count = '0;
        r.status = f.status;
        if (f.op == MODE_CAL)
        begin
            len_eff = (cal_len_cfg == 0) ? 1 : int'(cal_len_cfg);
            for (c = 0; c < FIELD_CHANNELS && c < NUM_LANES; c++)
            begin
                x = $signed(f.code[c]);
                a = (cal_count == 0) ? x : avg_mem[c];
                avg_mem[c] = (a + x) / 2;
            end
            cal_count = cal_count + 1'b1;
            if (int'(cal_count) < len_eff && cal_count != 0)
                return 1'b0;
            cal_count = '0;
            for (c = 0; c < FIELD_CHANNELS; c++)
            begin
                if (c < NUM_LANES)
                begin
                    offset_mem[c] = avg_mem[c];
                    v = offset_mem[c];
                    r.value[c] = v[VALUE_W-1:0];
                end
            end
            r.done = 1'b1;
            return 1'b1;
        end
        // any other mode is a measurement and abandons a partial calibration
        cal_count = '0;
        for (c = 0; c < FIELD_CHANNELS; c++)
        begin
            v = 0;
            if (c < NUM_LANES)
            begin
                v = $signed(f.code[c]);
                if (f.op == MODE_CORR)
                    v = v - offset_mem[c];
            end
            r.value[c] = v[VALUE_W-1:0];
        end
        return 1'b1;
    endfunction

    function automatic frame_t frame_of(input logic [MODE_W-1:0] op,
                                        input logic [STATUS_W-1:0] st,
                                        input logic [CODE_W-1:0] c0, c1, c2, c3);
        frame_t f;
        f.op = op;
        f.status = st;
        f.code[0] = c0;
        f.code[1] = c1;
        f.code[2] = c2;
        f.code[3] = c3;
        return f;
    endfunction

    function automatic result_t result_of(input logic [STATUS_W-1:0] st,
                                          input logic [VALUE_W-1:0] v0, v1, v2, v3,
                                          input logic done);
        result_t r;
        r.status = st;
        r.value[0] = v0;
        r.value[1] = v1;
        r.value[2] = v2;
        r.value[3] = v3;
        r.done = done;
        return r;
    endfunction

    // codes lean on the extremes now and then
    function automatic logic [CODE_W-1:0] rand_code();
        case ($urandom_range(9))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'hFFFFFF;
            3: return 24'h000000;
            default: return CODE_W'($urandom);
        endcase
    endfunction

    function automatic frame_t random_frame(input logic [MODE_W-1:0] op);
        return frame_of(op, STATUS_W'($urandom), rand_code(), rand_code(), rand_code(),
                        rand_code());
    endfunction

    function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // write one register while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_FRAMES_SKIPPED)
            skip_cfg = data[SKIP_W-1:0];
        else
            cal_len_cfg = data[CAL_LEN_W-1:0];
    endtask

    // offer one frame, hold it until the transfer, then queue what it should produce
    task automatic send_frame(input frame_t f, input logic typed, input result_t want);
        logic    taken;
        logic    has;
        result_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= f.op;
        status_word <= f.status;
        code_ch0 <= f.code[0];
        code_ch1 <= f.code[1];
        code_ch2 <= f.code[2];
        code_ch3 <= f.code[3];
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
        has = compute_frame_result(f, r);
        if (typed)
            owed_results.push_back(want);
        else if (has)
            owed_results.push_back(r);
        frames_sent++;
    endtask

    // drop valid and wait until every owed result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random phase built from calibration runs and short bursts of mixed modes
    task automatic run_phase(input logic [CFG_DATA_W-1:0] skip_data,
                             input logic [CFG_DATA_W-1:0] len_data,
                             input int s_pct, input int r_pct, input int n_items,
                             input int press);
        int          sent;
        int          burst;
        int          k;
        int          len_eff;
        logic        pressed;
        logic [MODE_W-1:0] op;
        write_reg(REG_FRAMES_SKIPPED, skip_data);
        write_reg(REG_CAL_LENGTH, len_data);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        sent = 0;
        pressed = 1'b0;
        while (sent < n_items)
        begin
            if (!pressed && sent >= n_items / 2)
            begin
                pressed = 1'b1;
                if (press == PRESS_HOLD)
                    hold_request = HOLD_CYCLES;
                else if (press == PRESS_PAUSE)
                    drain_results();
            end
            len_eff = (cal_len_cfg == 0) ? 1 : int'(cal_len_cfg);
            if ($urandom_range(9) < 6)
            begin
                // well-formed run: enough kept calibration frames to finish
                burst = (len_eff + $urandom_range(1)) * (int'(skip_cfg) + 1);
                for (k = 0; k < burst; k++)
                    send_frame(random_frame(MODE_CAL), 1'b0, '0);
            end
            else
            begin
                burst = $urandom_range(1, 4);
                for (k = 0; k < burst; k++)
                begin
                    case ($urandom_range(7))
                        0, 1, 2: op = MODE_RAW;
                        3, 4, 5: op = MODE_CORR;
                        6:       op = MODE_SPARE;
                        default: op = MODE_CAL;
                    endcase
                    send_frame(random_frame(op), 1'b0, '0);
                end
            end
            sent += burst;
        end
        drain_results();
    endtask

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        out_ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each transfer on the result side with the oldest owed result
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            results_seen++;
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: status_out %0h", status_out);
                mismatches++;
            end
            else
            begin
                got_result = owed_results.pop_front();
                if (got_result.done)
                    offsets_latched++;
                check_field("status_out", VALUE_W'(got_result.status), VALUE_W'(status_out));
                check_field("value_ch0", got_result.value[0], value_ch0);
                check_field("value_ch1", got_result.value[1], value_ch1);
                check_field("value_ch2", got_result.value[2], value_ch2);
                check_field("value_ch3", got_result.value[3], value_ch3);
                check_field("calibration_done", VALUE_W'(got_result.done),
                            VALUE_W'(calibration_done));
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results owed", cycle_count, owed_results.size());
        $display("adc_frame_offset_calibrator_test: done, errors");
        $finish;
    end

    initial
    begin
        int k;
        stim_row_t row;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        mode <= '0;
        status_word <= '0;
        code_ch0 <= '0;
        code_ch1 <= '0;
        code_ch2 <= '0;
        code_ch3 <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        mismatches = 0;
        frames_sent = 0;
        results_seen = 0;
        offsets_latched = 0;
        skip_cfg = FRAMES_SKIPPED_RST;
        cal_len_cfg = CAL_LENGTH_RST;
        skip_count = '0;
        cal_count = '0;
        for (k = 0; k < FIELD_CHANNELS; k++)
        begin
            offset_mem[k] = 0;
            avg_mem[k] = 0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset skip count: ten frames dropped, the eleventh kept
        for (k = 0; k < 11; k++)
            send_frame(random_frame(MODE_RAW), 1'b0, '0);
        drain_results();

        write_reg(REG_FRAMES_SKIPPED, 10'd0);
        write_reg(REG_CAL_LENGTH, 10'd2);

        // directed rows: extremes, every mode, a calibration run and its use
        directed_rows.push_back('{frame_of(MODE_RAW, 24'h000000, 24'h0, 24'h0, 24'h0, 24'h0),
            1'b1, result_of(24'h000000, 25'h0, 25'h0, 25'h0, 25'h0, 1'b0)});
        directed_rows.push_back('{frame_of(MODE_RAW, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
            24'hFFFFFF, 24'h000001), 1'b1, result_of(24'hFFFFFF, 25'h07FFFFF, 25'h1800000,
            25'h1FFFFFF, 25'h0000001, 1'b0)});
        directed_rows.push_back('{frame_of(MODE_CORR, 24'hA5A5A5, 24'h7FFFFF, 24'h800000,
            24'hFFFFFF, 24'h000001), 1'b1, result_of(24'hA5A5A5, 25'h07FFFFF, 25'h1800000,
            25'h1FFFFFF, 25'h0000001, 1'b0)});
        directed_rows.push_back('{frame_of(MODE_SPARE, 24'h5A5A5A, 24'h000001, 24'hFFFFFF,
            24'h800000, 24'h7FFFFF), 1'b1, result_of(24'h5A5A5A, 25'h0000001, 25'h1FFFFFF,
            25'h1800000, 25'h07FFFFF, 1'b0)});
        // first half of a two-frame run gives nothing
        directed_rows.push_back('{frame_of(MODE_CAL, 24'h123456, 24'd100, 24'hFFFF9C,
            24'h7FFFFF, 24'h800000), 1'b0, '0});
        // halving truncates toward zero on both signs
        directed_rows.push_back('{frame_of(MODE_CAL, 24'h654321, 24'd101, 24'hFFFF9B,
            24'h7FFFFF, 24'h800000), 1'b1, result_of(24'h654321, 25'd100, 25'h1FFFF9C,
            25'h07FFFFF, 25'h1800000, 1'b1)});
        // corrected values at both ends of the output range
        directed_rows.push_back('{frame_of(MODE_CORR, 24'h00FF00, 24'h0, 24'h0, 24'h800000,
            24'h7FFFFF), 1'b1, result_of(24'h00FF00, 25'h1FFFF9C, 25'd100, 25'h1000001,
            25'h0FFFFFF, 1'b0)});
        // a measurement frame abandons the partial run
        directed_rows.push_back('{random_frame(MODE_CAL), 1'b0, '0});
        directed_rows.push_back('{random_frame(MODE_RAW), 1'b0, '0});
        directed_rows.push_back('{random_frame(MODE_CAL), 1'b0, '0});
        directed_rows.push_back('{random_frame(MODE_CAL), 1'b0, '0});
        directed_rows.push_back('{random_frame(MODE_CORR), 1'b0, '0});
        directed_rows.push_back('{random_frame(MODE_SPARE), 1'b0, '0});

        for (k = 0; k < directed_rows.size(); k++)
        begin
            row = directed_rows[k];
            send_frame(row.f, row.typed, row.want);
        end
        drain_results();

        run_phase(10'd0, 10'd3, 0, 0, 50, PRESS_HOLD);
        run_phase(10'd1, 10'd1, 64, 0, 50, PRESS_NONE);
        run_phase(10'd0, 10'd0, 0, 64, 50, PRESS_NONE);
        run_phase(10'd2, 10'd5, 26, 26, 50, PRESS_PAUSE);
        run_phase(10'h3FF, 10'd1, 0, 0, 256, PRESS_NONE);

        // longest calibration run, no skipping
        write_reg(REG_FRAMES_SKIPPED, 10'd0);
        write_reg(REG_CAL_LENGTH, 10'd1023);
        send_idle_pct = 0;
        recv_stall_pct = 26;
        send_frame(random_frame(MODE_RAW), 1'b0, '0);
        for (k = 0; k < 1023; k++)
            send_frame(random_frame(MODE_CAL), 1'b0, '0);
        send_frame(random_frame(MODE_CORR), 1'b0, '0);
        drain_results();

        // lower the length under a run already past it
        write_reg(REG_CAL_LENGTH, 10'd10);
        send_frame(random_frame(MODE_RAW), 1'b0, '0);
        for (k = 0; k < 6; k++)
            send_frame(random_frame(MODE_CAL), 1'b0, '0);
        drain_results();
        write_reg(REG_CAL_LENGTH, 10'd3);
        send_frame(random_frame(MODE_CAL), 1'b0, '0);
        send_frame(random_frame(MODE_CORR), 1'b0, '0);
        drain_results();

        run_phase(10'd3, 10'd8, 26, 26, 25, PRESS_NONE);
        run_phase(10'd0, 10'd2, 0, 0, 25, PRESS_NONE);

        $display("covered %0d frames in, %0d results out, %0d offset latches, %0d mismatches",
                 frames_sent, results_seen, offsets_latched, mismatches);
        $display("skip 0..255, length 0..1023, all modes, stalls on both sides");
        if (mismatches == 0)
            $display("adc_frame_offset_calibrator_test: done, clean");
        else
            $display("adc_frame_offset_calibrator_test: done, errors");
        $finish;
    end

endmodule
